FILE: hdl/jdhd_pkg.sv
// Shared types, Huffman DC tables and register map for the JPEG DC decoder.
package jdhd_pkg;

    localparam int CAT_COUNT  = 12;
    localparam int CODE_W     = 11;
    localparam int CNT_W      = 4;
    localparam int CAT_W      = 4;
    localparam int COEF_W     = 12;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Register indexes (byte address / 4)
    localparam logic REG_TABLE_SELECT = 1'b0;

    // Standard DC tables: row 0 luminance, row 1 chrominance
    localparam logic [0:1][0:CAT_COUNT-1][CNT_W-1:0] DC_LEN = '{
        '{4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
        '{4'd2, 4'd2, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11}
    };
    localparam logic [0:1][0:CAT_COUNT-1][CODE_W-1:0] DC_CODE = '{
        '{11'h000, 11'h002, 11'h003, 11'h004, 11'h005, 11'h006,
          11'h00E, 11'h01E, 11'h03E, 11'h07E, 11'h0FE, 11'h1FE},
        '{11'h000, 11'h001, 11'h002, 11'h006, 11'h00E, 11'h01E,
          11'h03E, 11'h07E, 11'h0FE, 11'h1FE, 11'h3FE, 11'h7FE}
    };
    localparam logic [0:1][CNT_W-1:0] DC_MAXLEN = '{4'd9, 4'd11};

    typedef struct packed {
        logic start_req;
        logic bit_req;
    } in_req_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [CAT_W-1:0]         category;
        logic                     bad_code;
    } out_req_t;

    // Table lookup result for the current prefix
    typedef struct packed {
        logic             hit;
        logic [CAT_W-1:0] cat;
        logic             exhausted;
    } match_t;

endpackage

FILE: hdl/jpeg_dc_huffman_decoder_top.sv
// Top level of the JPEG baseline DC Huffman decoder with its APB register.
// A result is registered: it appears in the output register in the cycle after the request
//   that completes it (Huffman code of category 0, last extra bit, or bad code).
// Throughput: one bit request per cycle; the input stalls only while a result
//   sits unaccepted in the output register and out_ready is low.
// Reset (rst_n, async low): table_select = luminance, stream state cleared,
//   output register empty.
module jpeg_dc_huffman_decoder_top
    import jdhd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // bit stream requests
    input  logic               in_valid,
    output logic               in_ready,
    input  in_req_t            in_data,
    // decoded coefficients
    output logic               out_valid,
    input  logic               out_ready,
    output out_req_t           out_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic table_select_reg;
    logic reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_select_reg <= 1'b0;
        else if (psel && penable && pwrite && reg_index == REG_TABLE_SELECT)
            table_select_reg <= pwdata[0];
    end

    assign prdata = (reg_index == REG_TABLE_SELECT) ? PDATA_W'(table_select_reg) : '0;

    // ------------------------------------------------------------------
    // Stream state
    // ------------------------------------------------------------------
    logic [CODE_W-1:0] code_shift_reg,     code_shift_next;
    logic [CNT_W-1:0]  code_bit_count_reg, code_bit_count_next;
    logic              in_extra_reg,       in_extra_next;
    logic [CAT_W-1:0]  held_category_reg,  held_category_next;
    logic [CODE_W-1:0] extra_value_reg,    extra_value_next;
    logic [CAT_W-1:0]  extra_left_reg,     extra_left_next;
    logic              halted_reg,         halted_next;
    logic              out_valid_reg,      out_valid_next;
    out_req_t          out_data_reg;

    logic     accept;
    logic     res_valid;
    out_req_t res;

    // state as seen after an optional start clear
    logic [CODE_W-1:0] base_shift;
    logic [CNT_W-1:0]  base_count;
    logic              base_extra;
    logic [CAT_W-1:0]  base_held;
    logic [CODE_W-1:0] base_value;
    logic [CAT_W-1:0]  base_left;
    logic              base_halted;

    logic [CODE_W-1:0] shifted_code;
    logic [CNT_W-1:0]  count_inc;
    logic [CODE_W-1:0] shifted_value;
    logic [CAT_W-1:0]  left_dec;
    logic [CODE_W-1:0] neg_thresh;
    logic [COEF_W-1:0] cat_mask;
    logic [COEF_W-1:0] coef_raw;
    match_t            match;

    // the output register frees itself in the same cycle it is taken
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (in_data.start_req)
        begin
            base_shift  = '0;
            base_count  = '0;
            base_extra  = 1'b0;
            base_held   = '0;
            base_value  = '0;
            base_left   = '0;
            base_halted = 1'b0;
        end
        else
        begin
            base_shift  = code_shift_reg;
            base_count  = code_bit_count_reg;
            base_extra  = in_extra_reg;
            base_held   = held_category_reg;
            base_value  = extra_value_reg;
            base_left   = extra_left_reg;
            base_halted = halted_reg;
        end
    end

    assign shifted_code  = {base_shift[CODE_W-2:0], in_data.bit_req};
    assign count_inc     = (base_count != {CNT_W{1'b1}}) ? base_count + 1'b1 : base_count;
    assign shifted_value = {base_value[CODE_W-2:0], in_data.bit_req};
    assign left_dec      = base_left - 1'b1;

    jdhd_code_match u_match (
        .table_sel (table_select_reg),
        .code      (shifted_code),
        .count     (count_inc),
        .match     (match)
    );

    // extra value below 2^(cat-1) is negative: subtract 2^cat - 1
    assign neg_thresh = (base_held != '0) ? CODE_W'(1) << (base_held - 1'b1) : '0;
    assign cat_mask   = COEF_W'((COEF_W'(1) << base_held) - 1'b1);
    assign coef_raw   = (shifted_value < neg_thresh)
                        ? COEF_W'(shifted_value) - cat_mask
                        : COEF_W'(shifted_value);

    always_comb
    begin
        code_shift_next     = code_shift_reg;
        code_bit_count_next = code_bit_count_reg;
        in_extra_next       = in_extra_reg;
        held_category_next  = held_category_reg;
        extra_value_next    = extra_value_reg;
        extra_left_next     = extra_left_reg;
        halted_next         = halted_reg;
        res_valid           = 1'b0;
        res                 = '0;

        if (accept)
        begin
            code_shift_next     = base_shift;
            code_bit_count_next = base_count;
            in_extra_next       = base_extra;
            held_category_next  = base_held;
            extra_value_next    = base_value;
            extra_left_next     = base_left;
            halted_next         = base_halted;

            if (!base_halted)
            begin
                if (base_extra)
                begin
                    extra_value_next = shifted_value;
                    extra_left_next  = left_dec;
                    if (left_dec == '0)
                    begin
                        res_valid           = 1'b1;
                        res.coefficient     = $signed(coef_raw);
                        res.category        = base_held;
                        in_extra_next       = 1'b0;
                        extra_value_next    = '0;
                        code_shift_next     = '0;
                        code_bit_count_next = '0;
                    end
                end
                else
                begin
                    code_shift_next     = shifted_code;
                    code_bit_count_next = count_inc;
                    if (match.hit)
                    begin
                        code_shift_next     = '0;
                        code_bit_count_next = '0;
                        if (match.cat == '0)
                            res_valid = 1'b1;   // category 0: zero coefficient now
                        else
                        begin
                            held_category_next = match.cat;
                            extra_left_next    = match.cat;
                            extra_value_next   = '0;
                            in_extra_next      = 1'b1;
                        end
                    end
                    else if (match.exhausted)
                    begin
                        // all-ones prefix past the longest code
                        res_valid           = 1'b1;
                        res.bad_code        = 1'b1;
                        halted_next         = 1'b1;
                        code_shift_next     = '0;
                        code_bit_count_next = '0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (res_valid)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_shift_reg     <= '0;
            code_bit_count_reg <= '0;
            in_extra_reg       <= 1'b0;
            held_category_reg  <= '0;
            extra_value_reg    <= '0;
            extra_left_reg     <= '0;
            halted_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            code_shift_reg     <= code_shift_next;
            code_bit_count_reg <= code_bit_count_next;
            in_extra_reg       <= in_extra_next;
            held_category_reg  <= held_category_next;
            extra_value_reg    <= extra_value_next;
            extra_left_reg     <= extra_left_next;
            halted_reg         <= halted_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // result payload, loaded only when a request completes a coefficient or gives a bad code
    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a stalled input means a result is waiting
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg)
        else $error("input stalled with empty output register");

    // a bad code halts the decoder
    a_bad_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.bad_code) |=> halted_reg && code_bit_count_reg == '0)
        else $error("bad code did not halt the decoder");

    // halted decoder ignores requests without start
    a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && halted_reg && !in_data.start_req) |=> halted_reg && !in_extra_reg)
        else $error("halted decoder changed state");

    // extra-bit countdown stays within the held category
    a_extra_left: assert property (@(posedge clk) disable iff (!rst_n)
        in_extra_reg |-> (extra_left_reg != '0 && extra_left_reg <= held_category_reg))
        else $error("extra bit count out of range");

    // a partial code never reaches the longest code length
    a_code_len: assert property (@(posedge clk) disable iff (!rst_n)
        code_bit_count_reg < DC_MAXLEN[1])
        else $error("partial code too long");

endmodule

FILE: hdl/jdhd_code_match.sv
// Parallel prefix compare against the twelve codes of the selected DC table.
module jdhd_code_match
    import jdhd_pkg::*;
(
    input  logic              table_sel,
    input  logic [CODE_W-1:0] code,
    input  logic [CNT_W-1:0]  count,
    output match_t            match
);

    always_comb
    begin
        match.hit       = 1'b0;
        match.cat       = '0;
        // codes are prefix-free, so at most one entry hits
        for (int c = 0; c < CAT_COUNT; c++)
        begin
            if (DC_LEN[table_sel][c] == count && DC_CODE[table_sel][c] == code)
            begin
                match.hit = 1'b1;
                match.cat = CAT_W'(c);
            end
        end
        match.exhausted = (count >= DC_MAXLEN[table_sel]);
    end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the JPEG baseline DC Huffman decoder top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import jdhd_pkg::*;

    // Reset is held low at the start. The receiver's long hold-off is measured
    // in cycles. The run is cut off if it goes on past the limit below.
    localparam int RESET_CYCLES = 3;
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE_WAIT  = 4;
    localparam int RUN_LIMIT_NS = 5_000_000;

    // Annex K DC tables, kept separately from the RTL.
    // Row 0 is luminance and row 1 is chrominance; the index is the category.
    localparam logic TBL_LUMA   = 1'b0;
    localparam logic TBL_CHROMA = 1'b1;
    localparam logic [3:0] HUFF_LEN [2][12] = '{
        '{4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
        '{4'd2, 4'd2, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11}
    };
    localparam logic [10:0] HUFF_CODE [2][12] = '{
        '{11'h000, 11'h002, 11'h003, 11'h004, 11'h005, 11'h006,
          11'h00E, 11'h01E, 11'h03E, 11'h07E, 11'h0FE, 11'h1FE},
        '{11'h000, 11'h001, 11'h002, 11'h006, 11'h00E, 11'h01E,
          11'h03E, 11'h07E, 11'h0FE, 11'h1FE, 11'h3FE, 11'h7FE}
    };
    localparam logic [3:0] HUFF_MAXLEN [2] = '{4'd9, 4'd11};

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    in_req_t            in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_req_t           out_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    jpeg_dc_huffman_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder prediction: our own copy of the stream state and the register
    // ------------------------------------------------------------------
    logic        cur_table  = TBL_LUMA;
    logic [10:0] code_bits  = '0;
    logic [3:0]  code_len   = '0;
    logic        in_extra   = 1'b0;
    logic [3:0]  pend_cat   = '0;
    logic [10:0] extra_bits = '0;
    logic [3:0]  extra_cnt  = '0;
    logic        stopped    = 1'b0;

    out_req_t    expected_coefs[$];
    out_req_t    want_res;
    int          mismatch_cnt = 0;
    int          stream_items = 0;

    // Knobs for the traffic shaping
    logic        idle_on  = 1'b1;
    logic        hold_req = 1'b0;
    int          tx_calm  = 0;
    int          rx_calm  = 0;

    // Advances the predicted state by one accepted request. Any coefficient it
    // finishes, or bad code it finds, is queued as the next expected result.
    task automatic decode_bit(input in_req_t req);
        out_req_t res;
        int       value;
        int       cat;
        logic     hit;
        if (req.start_req)
        begin
            code_bits  = '0;
            code_len   = '0;
            in_extra   = 1'b0;
            pend_cat   = '0;
            extra_bits = '0;
            extra_cnt  = '0;
            stopped    = 1'b0;
        end
        if (stopped)
            return;

        if (in_extra)
        begin
            extra_bits = {extra_bits[9:0], req.bit_req};
            extra_cnt  = extra_cnt - 4'd1;
            if (extra_cnt == 4'd0)
            begin
                // An extra value below half the range encodes a negative coefficient.
                value = int'(extra_bits);
                if (pend_cat >= 1 && extra_bits < (11'd1 << (pend_cat - 1)))
                    value = value - ((1 << pend_cat) - 1);
                res.coefficient = value[COEF_W-1:0];
                res.category    = pend_cat;
                res.bad_code    = 1'b0;
                expected_coefs = {expected_coefs, res};
                in_extra   = 1'b0;
                extra_bits = '0;
                code_bits  = '0;
                code_len   = '0;
            end
            return;
        end

        code_bits = {code_bits[9:0], req.bit_req};
        if (code_len < 4'd15)
            code_len = code_len + 4'd1;

        hit = 1'b0;
        cat = 0;
        for (int c = 0; c < CAT_COUNT; c++)
        begin
            if (!hit && HUFF_LEN[cur_table][c] == code_len
                     && HUFF_CODE[cur_table][c] == code_bits)
            begin
                hit = 1'b1;
                cat = c;
            end
        end

        if (hit)
        begin
            code_bits = '0;
            code_len  = '0;
            if (cat == 0)
            begin
                res = '0;
                expected_coefs = {expected_coefs, res};
            end
            else
            begin
                pend_cat   = cat[3:0];
                extra_cnt  = cat[3:0];
                extra_bits = '0;
                in_extra   = 1'b1;
            end
        end
        else if (code_len >= HUFF_MAXLEN[cur_table])
        begin
            // The prefix is too long for every code in the table. The block
            // halts until the next start.
            res          = '0;
            res.bad_code = 1'b1;
            expected_coefs = {expected_coefs, res};
            stopped   = 1'b1;
            code_bits = '0;
            code_len  = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Driving the bit stream
    // ------------------------------------------------------------------
    // Presents one bit request and holds it until it is accepted. It then
    // updates the prediction and may drop valid for a random burst. Valid
    // stays high from one request to the next unless a burst is taken.
    task automatic send_bit(input logic st, input logic b);
        in_req_t req;
        req.start_req = st;
        req.bit_req   = b;
        if (!stopped || st)
            stream_items++;
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        decode_bit(req);
        if (tx_calm > 0)
            tx_calm--;
        else if ($urandom_range(0, 59) == 0)
            tx_calm = $urandom_range(20, 80);
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Sends the code for a category followed by its extra bits, both MSB
    // first. It stops after cut bits, which is how broken symbols are made.
    task automatic send_symbol(input int cat, input int extra, input logic st,
                               input int cut);
        int          len;
        logic [10:0] code;
        len  = int'(HUFF_LEN[cur_table][cat]);
        code = HUFF_CODE[cur_table][cat];
        for (int i = 0; i < len + cat && i < cut; i++)
        begin
            if (i < len)
                send_bit(st && i == 0, code[len - 1 - i]);
            else
                send_bit(1'b0, extra[cat - 1 - (i - len)]);
        end
    endtask

    // Lets the block go idle. The register may be written only then.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_coefs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // APB write: a setup phase, then an access phase. The register takes the
    // new value at the edge where pready is seen.
    task automatic write_table_select(input logic sel);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(REG_TABLE_SELECT));
        pwdata  <= PDATA_W'(sel);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_table = sel;
    endtask

    // Extra bits are biased toward all zeros and all ones, which give the
    // extreme coefficient values.
    function automatic int pick_extra(input int cat);
        int sel;
        sel = $urandom_range(0, 3);
        if (cat == 0 || sel == 0)
            return 0;
        if (sel == 1)
            return (1 << cat) - 1;
        return $urandom_range(0, (1 << cat) - 1);
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_coefs.size() == 0)
            begin
                $display("%0t: unexpected result coef=%0d cat=%0d bad=%0b",
                         $time, out_data.coefficient, out_data.category,
                         out_data.bad_code);
                mismatch_cnt++;
            end
            else
            begin
                want_res = expected_coefs.pop_front();
                if (out_data.coefficient !== want_res.coefficient)
                begin
                    $display("%0t: coefficient expected %0d actual %0d", $time,
                             want_res.coefficient, out_data.coefficient);
                    mismatch_cnt++;
                end
                if (out_data.category !== want_res.category)
                begin
                    $display("%0t: category expected %0d actual %0d", $time,
                             want_res.category, out_data.category);
                    mismatch_cnt++;
                end
                if (out_data.bad_code !== want_res.bad_code)
                begin
                    $display("%0t: bad_code expected %0b actual %0b", $time,
                             want_res.bad_code, out_data.bad_code);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Receiver: random stall bursts with calm stretches in between. When
    // hold_req is set, it holds out_ready low for the long hold-off, then clears hold_req.
    always
    begin
        @(posedge clk);
        if (hold_req)
        begin
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            out_ready <= 1'b1;
            hold_req = 1'b0;
        end
        else if (rx_calm > 0)
        begin
            rx_calm--;
            out_ready <= 1'b1;
        end
        else if ($urandom_range(0, 59) == 0)
        begin
            rx_calm = $urandom_range(20, 80);
            out_ready <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 6) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
            out_ready <= 1'b1;
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Luminance basics:
    // - the first bit of a stream may carry start;
    // - category 1 with a zero extra bit gives -1;
    // - start drops a partial code;
    // - an all-ones prefix is a bad code, after which the block halts;
    // - start clears the halt.
    task automatic test_luma_basics();
        write_table_select(TBL_LUMA);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_symbol(1, 0, 1'b0, 32);
        send_bit(1'b0, 1'b1);
        // Nine ones with start on the first: start drops the partial bit above,
        // and the ones then give a bad code.
        for (int i = 0; i < 9; i++)
            send_bit(i == 0, 1'b1);
        send_bit(1'b0, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        settle();
    endtask

    // Chroma decode. Then the table is switched in the middle of a code: ten
    // ones are a valid chroma prefix, but they are already too long for luma.
    task automatic test_table_change();
        write_table_select(TBL_CHROMA);
        send_symbol(1, 1, 1'b1, 32);
        for (int i = 0; i < 10; i++)
            send_bit(1'b0, 1'b1);
        settle();
        write_table_select(TBL_LUMA);
        send_bit(1'b0, 1'b1);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        settle();
    endtask

    // Mostly well-formed symbols with random categories and extra bits.
    // The rest is noise, all-ones bad codes and symbols cut short.
    task automatic test_random_stream(input logic tbl, input int n_items);
        int   goal;
        int   kind;
        int   cat;
        int   extra;
        logic st;
        logic need_start;
        write_table_select(tbl);
        goal       = stream_items + n_items;
        need_start = 1'b1;
        while (stream_items < goal)
        begin
            kind  = $urandom_range(0, 19);
            cat   = $urandom_range(0, 11);
            extra = pick_extra(cat);
            st    = need_start || stopped || $urandom_range(0, 9) == 0;
            need_start = 1'b0;
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 12))
                    send_bit($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
                need_start = 1'b1;
            end
            else if (kind == 1)
            begin
                for (int i = 0; i < HUFF_MAXLEN[cur_table]; i++)
                    send_bit(st && i == 0, 1'b1);
            end
            else if (kind == 2)
            begin
                send_symbol(cat, extra, st,
                            $urandom_range(1, HUFF_LEN[cur_table][cat] + cat - 1));
                need_start = 1'b1;
            end
            else
                send_symbol(cat, extra, st, 32);
        end
        settle();
    endtask

    // The receiver holds off while category-0 symbols keep arriving, so the
    // block fills and stalls its input. After that the sender waits until
    // every result has arrived, then carries on.
    task automatic test_output_hold();
        write_table_select(TBL_CHROMA);
        hold_req = 1'b1;
        send_symbol(0, 0, 1'b1, 32);
        repeat (40)
            send_symbol(0, 0, 1'b0, 32);
        settle();
        repeat (10)
            send_symbol($urandom_range(0, 3), 1, 1'b0, 32);
        settle();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_luma_basics();
        test_table_change();
        test_random_stream(TBL_LUMA, 350);
        test_random_stream(TBL_CHROMA, 350);
        test_output_hold();
        test_random_stream(TBL_LUMA, 350);
        test_random_stream(TBL_CHROMA, 350);
        // Final stretch runs with no idling on either side.
        idle_on = 1'b0;
        test_random_stream(TBL_LUMA, 300);

        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout, %0d results still expected", $time,
                 expected_coefs.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/jdhd_pkg.sv
hdl/jdhd_code_match.sv
hdl/jpeg_dc_huffman_decoder_top.sv
verif/tb_top.sv
